@@ hdl/mgr_pkg.sv @@
package mgr_pkg;

   localparam int NUM_GATES      = 8;
   localparam int TICKS_PER_BEAT = 24;
   localparam int CC_ON_LEVEL    = 63;

   localparam int GATE_CNT_W = 4;
   localparam int COUNT_W    = 32;
   localparam int DIV_W      = 8;

   // remainder unit: bits of the dividend consumed per cycle
   localparam int MOD_STEP_BITS = 4;
   localparam int MOD_STEPS     = COUNT_W / MOD_STEP_BITS;
   localparam int MOD_CNT_W     = $clog2(MOD_STEPS);

   typedef enum logic [2:0] {
      CMD_NOTE      = 3'd0,
      CMD_MONO      = 3'd1,
      CMD_DUO       = 3'd2,
      CMD_TRI       = 3'd3,
      CMD_CC        = 3'd4,
      CMD_TICK      = 3'd5,
      CMD_TRANSPORT = 3'd6
   } cmd_type;

   typedef enum logic [1:0] {
      XPORT_START    = 2'd0,
      XPORT_CONTINUE = 2'd1,
      XPORT_STOP     = 2'd2,
      XPORT_OTHER    = 2'd3
   } xport_type;

   typedef enum logic [2:0] {
      CSR_GATE_SOURCES  = 3'd0,
      CSR_GATE_NOTES    = 3'd1,
      CSR_GATE_INVERTS  = 3'd2,
      CSR_CLOCK_DIVS    = 3'd3,
      CSR_RESET_BEATS   = 3'd4,
      CSR_CC_NUMBERS    = 3'd5
   } csr_idx_type;

   localparam logic [4:0] SRC_NOTE      = 5'd1;
   localparam logic [4:0] SRC_MONO      = 5'd2;
   localparam logic [4:0] SRC_DUO1      = 5'd3;
   localparam logic [4:0] SRC_TRI1      = 5'd5;
   localparam logic [4:0] SRC_CC1       = 5'd8;
   localparam logic [4:0] SRC_CLK1      = 5'd11;
   localparam logic [4:0] SRC_RST1      = 5'd19;
   localparam logic [4:0] SRC_TRANSPORT = 5'd22;
   localparam logic [4:0] NUM_CC        = 5'd3;
   localparam logic [4:0] NUM_CLK       = 5'd8;
   localparam logic [4:0] NUM_RST       = 5'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TICK,
      ST_BEAT,
      ST_RESET,
      ST_CLOCK,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [2:0] cmd;
      logic [6:0] note;
      logic       is_on;
      logic [1:0] voice;
      logic [6:0] cc_number;
      logic [6:0] cc_value;
      logic [6:0] mono_note;
      logic [1:0] transport_code;
   } evt_type;

   typedef struct packed {
      logic [7:0] wmask;
      logic [7:0] levels;
      logic [7:0] trig;
   } lvl_type;

   typedef struct packed {
      logic               start;
      logic [COUNT_W-1:0] dividend;
      logic [DIV_W-1:0]   divisor;
   } mod_req_type;

   typedef struct packed {
      logic done;
      logic zero;
   } mod_rsp_type;

   function automatic logic [4:0] src_of(input logic [39:0] srcs, input logic [2:0] g);
      return srcs[5*g +: 5];
   endfunction

   function automatic logic [7:0] byte_of(input logic [63:0] v, input logic [2:0] k);
      return v[8*k +: 8];
   endfunction

endpackage

@@ hdl/midi_gate_router_clock_divider_unit.sv @@
// channel  direction  handshake             payload
// req      in         req_valid/req_stall   cmd, note, is_on, voice, cc_*, mono note, transport
// rsp      out        rsp_valid/rsp_stall   level_write_mask, gate_levels, trigger_mask
// csr      in         csr_valid/csr_ready   csr_index, csr_data (always ready)
//
// non-tick words pass from accept through ST_DONE into the result register
// a tick word runs its remainders one at a time on the shared 4-bit-per-cycle unit:
// one for the beat check while playing, one per nonzero beat interval once a beat lands
// (walking all three intervals) and one per clock-sourced gate with a nonzero divisor
// req_stall is high from accept until the result loads; a stalled rsp delays only the load
// reset is synchronous and clears counters, transport state and config registers
module midi_gate_router_clock_divider_unit
   import mgr_pkg::*;
#(
   parameter int GATE_COUNT = NUM_GATES,
   parameter int BEAT_TICKS = TICKS_PER_BEAT
)
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_cmd,
   input  logic [6:0]  req_note,
   input  logic        req_is_on,
   input  logic [1:0]  req_voice,
   input  logic [6:0]  req_cc_number,
   input  logic [6:0]  req_cc_value,
   input  logic [6:0]  req_current_mono_note,
   input  logic [1:0]  req_transport_code,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_level_write_mask,
   output logic [7:0]  rsp_gate_levels,
   output logic [7:0]  rsp_trigger_mask,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data
);

   localparam logic [DIV_W-1:0] TPB_DIV = DIV_W'(BEAT_TICKS);

   logic [39:0] src_ff;
   logic [55:0] notes_ff;
   logic [7:0]  inv_ff;
   logic [63:0] clkdiv_ff;
   logic [23:0] rstbeat_ff;
   logic [20:0] ccnum_ff;

   state_type             state_ff, state_in;
   evt_type               evt_ff, evt_in;
   logic [COUNT_W-1:0]    tick_ff, tick_in;
   logic [COUNT_W-1:0]    start_ff, start_in;
   logic [COUNT_W-1:0]    beat_ff, beat_in;
   logic                  play_ff, play_in;
   logic [GATE_CNT_W-1:0] gate_ff, gate_in;
   logic [1:0]            k_ff, k_in;
   logic                  op_busy_ff, op_busy_in;
   logic [2:0]            fire_ff, fire_in;
   logic [7:0]            trig_ff, trig_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [7:0]            out_wmask_ff, out_wmask_in;
   logic [7:0]            out_levels_ff, out_levels_in;
   logic [7:0]            out_trig_ff, out_trig_in;

   logic               req_accept;
   logic [COUNT_W-1:0] pos;
   logic [4:0]         s;
   logic [4:0]         clk_idx;
   logic [4:0]         rst_idx;
   logic [DIV_W-1:0]   d;
   mod_req_type        mod_req;
   mod_rsp_type        mod_rsp;
   lvl_type            lvl;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;

   mgr_level_dec #(
      .GATE_COUNT (GATE_COUNT)
   ) u_dec (
      .evt          (evt_ff),
      .gate_sources (src_ff),
      .gate_notes   (notes_ff),
      .gate_inverts (inv_ff),
      .cc_numbers   (ccnum_ff),
      .lvl          (lvl)
   );

   mgr_mod_unit u_mod (
      .clock (clock),
      .reset (reset),
      .req   (mod_req),
      .rsp   (mod_rsp)
   );

   always_comb begin
      state_in      = state_ff;
      evt_in        = evt_ff;
      tick_in       = tick_ff;
      start_in      = start_ff;
      beat_in       = beat_ff;
      play_in       = play_ff;
      gate_in       = gate_ff;
      k_in          = k_ff;
      op_busy_in    = op_busy_ff;
      fire_in       = fire_ff;
      trig_in       = trig_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      out_wmask_in  = out_wmask_ff;
      out_levels_in = out_levels_ff;
      out_trig_in   = out_trig_ff;

      pos     = tick_ff - start_ff;
      s       = src_of(src_ff, gate_ff[2:0]);
      clk_idx = 5'(s - SRC_CLK1);
      rst_idx = 5'(s - SRC_RST1);
      d       = byte_of(clkdiv_ff, clk_idx[2:0]);

      mod_req.start    = 1'b0;
      mod_req.dividend = tick_ff;
      mod_req.divisor  = d;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               evt_in.cmd            = req_cmd;
               evt_in.note           = req_note;
               evt_in.is_on          = req_is_on;
               evt_in.voice          = req_voice;
               evt_in.cc_number      = req_cc_number;
               evt_in.cc_value       = req_cc_value;
               evt_in.mono_note      = req_current_mono_note;
               evt_in.transport_code = req_transport_code;
               gate_in    = '0;
               k_in       = '0;
               op_busy_in = 1'b0;
               fire_in    = '0;
               trig_in    = '0;
               state_in   = ST_DONE;
               if (req_cmd == CMD_TICK) begin
                  tick_in  = tick_ff + 1'b1;
                  state_in = ST_TICK;
               end else if (req_cmd == CMD_TRANSPORT) begin
                  if (req_transport_code == XPORT_START ||
                      req_transport_code == XPORT_CONTINUE) begin
                     start_in = tick_ff;
                     beat_in  = '0;
                     play_in  = 1'b1;
                  end else if (req_transport_code == XPORT_STOP) begin
                     play_in = 1'b0;
                  end
               end
            end
         end
         ST_TICK: begin
            if (play_ff && (pos != '0)) begin
               mod_req.start    = 1'b1;
               mod_req.dividend = pos;
               mod_req.divisor  = TPB_DIV;
               state_in         = ST_BEAT;
            end else begin
               state_in = ST_CLOCK;
            end
         end
         ST_BEAT: begin
            if (mod_rsp.done) begin
               if (mod_rsp.zero) begin
                  beat_in  = beat_ff + 1'b1;
                  state_in = ST_RESET;
               end else begin
                  state_in = ST_CLOCK;
               end
            end
         end
         ST_RESET: begin
            if (op_busy_ff) begin
               if (mod_rsp.done) begin
                  fire_in[k_ff] = mod_rsp.zero;
                  k_in          = 2'(k_ff + 1'b1);
                  op_busy_in    = 1'b0;
               end
            end else if (k_ff == 2'(NUM_RST)) begin
               state_in = ST_CLOCK;
            end else if (byte_of({40'd0, rstbeat_ff}, {1'b0, k_ff}) == '0) begin
               k_in = 2'(k_ff + 1'b1);
            end else begin
               mod_req.start    = 1'b1;
               mod_req.dividend = beat_ff;
               mod_req.divisor  = byte_of({40'd0, rstbeat_ff}, {1'b0, k_ff});
               op_busy_in       = 1'b1;
            end
         end
         ST_CLOCK: begin
            if (op_busy_ff) begin
               if (mod_rsp.done) begin
                  trig_in[gate_ff[2:0]] = mod_rsp.zero;
                  gate_in               = GATE_CNT_W'(gate_ff + 1'b1);
                  op_busy_in            = 1'b0;
               end
            end else if (gate_ff == GATE_CNT_W'(GATE_COUNT)) begin
               state_in = ST_DONE;
            end else if ((s >= SRC_CLK1) && (s < 5'(SRC_CLK1 + NUM_CLK)) && (d != '0)) begin
               mod_req.start = 1'b1;
               op_busy_in    = 1'b1;
            end else begin
               if ((s >= SRC_RST1) && (s < 5'(SRC_RST1 + NUM_RST))) begin
                  trig_in[gate_ff[2:0]] = fire_ff[rst_idx[1:0]];
               end
               gate_in = GATE_CNT_W'(gate_ff + 1'b1);
            end
         end
         ST_DONE: begin
            // load once the output register is free or being emptied
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               out_wmask_in  = lvl.wmask;
               out_levels_in = lvl.levels;
               out_trig_in   = lvl.trig | trig_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tick_ff      <= '0;
         start_ff     <= '0;
         beat_ff      <= '0;
         play_ff      <= 1'b0;
         gate_ff      <= '0;
         k_ff         <= '0;
         op_busy_ff   <= 1'b0;
         fire_ff      <= '0;
         trig_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tick_ff      <= tick_in;
         start_ff     <= start_in;
         beat_ff      <= beat_in;
         play_ff      <= play_in;
         gate_ff      <= gate_in;
         k_ff         <= k_in;
         op_busy_ff   <= op_busy_in;
         fire_ff      <= fire_in;
         trig_ff      <= trig_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      evt_ff        <= evt_in;
      out_wmask_ff  <= out_wmask_in;
      out_levels_ff <= out_levels_in;
      out_trig_ff   <= out_trig_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_ff     <= '0;
         notes_ff   <= '0;
         inv_ff     <= '0;
         clkdiv_ff  <= '0;
         rstbeat_ff <= '0;
         ccnum_ff   <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_GATE_SOURCES: src_ff     <= csr_data[39:0];
            CSR_GATE_NOTES:   notes_ff   <= csr_data[55:0];
            CSR_GATE_INVERTS: inv_ff     <= csr_data[7:0];
            CSR_CLOCK_DIVS:   clkdiv_ff  <= csr_data;
            CSR_RESET_BEATS:  rstbeat_ff <= csr_data[23:0];
            CSR_CC_NUMBERS:   ccnum_ff   <= csr_data[20:0];
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_level_write_mask = out_wmask_ff;
   assign rsp_gate_levels      = out_levels_ff;
   assign rsp_trigger_mask     = out_trig_ff;

endmodule

@@ hdl/mgr_mod_unit.sv @@
module mgr_mod_unit
   import mgr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  mod_req_type req,
   output mod_rsp_type rsp
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [MOD_CNT_W-1:0] cnt_ff, cnt_in;
   logic [COUNT_W-1:0]   quo_ff, quo_in;
   logic [DIV_W-1:0]     rem_ff, rem_in;
   logic [DIV_W-1:0]     div_ff, div_in;

   logic [DIV_W:0]       t;
   logic [DIV_W-1:0]     r;
   logic [COUNT_W-1:0]   q;

   // restoring remainder, MOD_STEP_BITS dividend bits per cycle
   always_comb begin
      r = rem_ff;
      q = quo_ff;
      t = '0;
      for (int i = 0; i < MOD_STEP_BITS; i++) begin
         t = {r, q[COUNT_W-1]};
         q = {q[COUNT_W-2:0], 1'b0};
         if (t >= {1'b0, div_ff}) begin
            r = DIV_W'(t - {1'b0, div_ff});
         end else begin
            r = t[DIV_W-1:0];
         end
      end

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = req.dividend;
         rem_in  = '0;
         div_in  = req.divisor;
      end else if (busy_ff) begin
         quo_in = q;
         rem_in = r;
         cnt_in = MOD_CNT_W'(cnt_ff + 1'b1);
         if (cnt_ff == MOD_CNT_W'(MOD_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign rsp.done = done_ff;
   assign rsp.zero = (rem_ff == '0);

endmodule

@@ hdl/mgr_level_dec.sv @@
module mgr_level_dec
   import mgr_pkg::*;
#(
   parameter int GATE_COUNT = NUM_GATES
)
(
   input  evt_type     evt,
   input  logic [39:0] gate_sources,
   input  logic [55:0] gate_notes,
   input  logic [7:0]  gate_inverts,
   input  logic [20:0] cc_numbers,
   output lvl_type     lvl
);

   logic [4:0] s;
   logic [4:0] cc_idx;
   logic       w;
   logic       on;

   always_comb begin
      lvl    = '0;
      s      = '0;
      cc_idx = '0;
      w      = 1'b0;
      on     = 1'b0;
      for (int g = 0; g < GATE_COUNT; g++) begin
         s      = gate_sources[5*g +: 5];
         cc_idx = 5'(s - SRC_CC1);
         w      = 1'b0;
         on     = evt.is_on;
         unique case (evt.cmd)
            CMD_NOTE: begin
               w = (s == SRC_NOTE) && (gate_notes[7*g +: 7] == evt.note);
            end
            CMD_MONO: begin
               // mono note off only for the note still held
               w = (s == SRC_MONO) && (evt.is_on || (evt.mono_note == evt.note));
            end
            CMD_DUO: begin
               w = (evt.voice == 2'd1 || evt.voice == 2'd2) &&
                   (s == 5'(SRC_DUO1 + evt.voice - 1'b1));
            end
            CMD_TRI: begin
               w = (evt.voice != 2'd0) && (s == 5'(SRC_TRI1 + evt.voice - 1'b1));
            end
            CMD_CC: begin
               on = (evt.cc_value > 7'(CC_ON_LEVEL));
               w  = (s >= SRC_CC1) && (s < 5'(SRC_CC1 + NUM_CC)) &&
                    (cc_numbers[7*cc_idx[1:0] +: 7] == evt.cc_number);
            end
            CMD_TRANSPORT: begin
               on = (evt.transport_code == XPORT_START) ||
                    (evt.transport_code == XPORT_CONTINUE);
               if (s == SRC_TRANSPORT) begin
                  w = on || (evt.transport_code == XPORT_STOP);
               end else if ((s >= SRC_RST1) && (s < 5'(SRC_RST1 + NUM_RST))) begin
                  lvl.trig[g] = 1'b1;
               end
            end
            default: begin
               w = 1'b0;
            end
         endcase
         lvl.wmask[g]  = w;
         lvl.levels[g] = w & (on ^ gate_inverts[g]);
      end
   end

endmodule
